@@ sv/pmpd_pkg.sv @@
// pmpd_pkg: shared types and constants for the PS/2 mouse packet decoder.
// Holds register map, status/flag masks and the packet command struct.
// No dependencies.
package pmpd_pkg;

    // Configuration port geometry
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PACKET_LENGTH = 2'd2;

    // Register widths and reset values
    localparam int SIZE_W = 13;
    localparam int LEN_W  = 3;
    localparam logic [SIZE_W-1:0] SCREEN_WIDTH_RST  = 13'd1280;
    localparam logic [SIZE_W-1:0] SCREEN_HEIGHT_RST = 13'd720;
    localparam logic [LEN_W-1:0]  PACKET_LENGTH_RST = 3'd3;
    localparam logic [LEN_W-1:0]  LEN_WHEEL         = 3'd4;

    // Controller status bits
    localparam logic [7:0] STATUS_OBF = 8'h01;
    localparam logic [7:0] STATUS_AUX = 8'h20;

    // First-byte flag bits
    localparam logic [7:0] FLAG_SYNC  = 8'h08;
    localparam logic [7:0] FLAG_XSIGN = 8'h10;
    localparam logic [7:0] FLAG_YSIGN = 8'h20;
    localparam logic [7:0] FLAG_XOVF  = 8'h40;
    localparam logic [7:0] FLAG_YOVF  = 8'h80;
    localparam logic [7:0] BTN_MASK   = 8'h07;

    // Fourth-byte fields
    localparam logic [7:0] WHEEL_MASK = 8'h0F;
    localparam logic [7:0] B3_MIDDLE  = 8'h10;

    // Cursor reset position (limited to the coordinate range where used)
    localparam int CUR_X_RST = 640;
    localparam int CUR_Y_RST = 360;

    // Completed packet, handed from the byte assembler to the cursor stage
    typedef struct packed {
        logic signed [8:0] dx;
        logic signed [8:0] dy;
        logic [2:0]        buttons;
        logic [3:0]        wheel;
        logic [15:0]       sync_count;
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);

endpackage

@@ sv/ps2_mouse_packet_decoder_core.sv @@
// ps2_mouse_packet_decoder_core: top level of the PS/2 mouse packet decoder.
// Instantiates pmpd_front, pmpd_queue (x2) and pmpd_back; depends on pmpd_pkg.
//
// Takes one controller status/data byte per cycle (push while full is low).
// Bytes without both the output-full and auxiliary status bits are dropped;
// a first byte without the sync bit is dropped and counted. Completed 3- or
// 4-byte packets go through a two-entry command queue to the cursor stage,
// which moves and clamps the cursor and writes the result into a two-entry
// result queue read with pop/empty. Sustained rate is one byte per cycle while
// full is low; full rises only when both command entries are held because
// results are not being popped. Configuration registers (width 0x0, height
// 0x4, packet length 0x8) are written over the APB port; the user must write
// them only while the block is idle, as the block itself does not enforce it.
module ps2_mouse_packet_decoder_core #(
    parameter int COORD_BITS = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pmpd_pkg::PADDR_W-1:0]   paddr,
    input  logic [pmpd_pkg::PDATA_W-1:0]   pwdata,
    output logic [pmpd_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    // Byte input
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     ctrl_status,
    input  logic [7:0]                     rx_byte,
    // Result output
    output logic                           empty,
    input  logic                           pop,
    output logic [COORD_BITS-1:0]          pos_x,
    output logic [COORD_BITS-1:0]          pos_y,
    output logic [2:0]                     button_bits,
    output logic signed [3:0]              wheel_step,
    output logic [15:0]                    sync_error_count
);
    import pmpd_pkg::*;

    localparam int RES_W = 2 * COORD_BITS + 3 + 4 + 16;

    logic [SIZE_W-1:0] screen_width_reg;
    logic [SIZE_W-1:0] screen_height_reg;
    logic [LEN_W-1:0]  packet_length_reg;
    logic              cfg_write;
    logic [1:0]        reg_index;

    logic              cmd_push, cmd_full, cmd_pop, cmd_empty;
    cmd_t              cmd_in, cmd_out;
    logic [CMD_W-1:0]  cmd_rdata;

    logic              res_push, res_full;
    logic [COORD_BITS-1:0] new_x, new_y;
    logic [2:0]        new_buttons;
    logic [3:0]        new_wheel;
    logic [15:0]       new_sync;
    logic [RES_W-1:0]  res_rdata;

    // Configuration registers
    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
            packet_length_reg <= PACKET_LENGTH_RST;
        end
        else if (cfg_write)
        begin
            if (reg_index == REG_SCREEN_WIDTH)
            begin
                screen_width_reg <= pwdata[SIZE_W-1:0];
            end
            if (reg_index == REG_SCREEN_HEIGHT)
            begin
                screen_height_reg <= pwdata[SIZE_W-1:0];
            end
            if (reg_index == REG_PACKET_LENGTH)
            begin
                packet_length_reg <= pwdata[LEN_W-1:0];
            end
        end
    end

    // Register readback
    always_comb
    begin
        unique case (reg_index)
            REG_SCREEN_WIDTH:  prdata = PDATA_W'(screen_width_reg);
            REG_SCREEN_HEIGHT: prdata = PDATA_W'(screen_height_reg);
            REG_PACKET_LENGTH: prdata = PDATA_W'(packet_length_reg);
            default:           prdata = '0;
        endcase
    end

    // Byte filter and packet assembly
    pmpd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .ctrl_status   (ctrl_status),
        .rx_byte       (rx_byte),
        .packet_length (packet_length_reg),
        .cmd_full      (cmd_full),
        .cmd_push      (cmd_push),
        .cmd           (cmd_in)
    );

    // Command queue between assembler and cursor stage
    pmpd_queue #(
        .WIDTH (CMD_W)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_rdata),
        .empty (cmd_empty)
    );

    assign cmd_out = cmd_t'(cmd_rdata);

    // Cursor stage
    pmpd_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_empty     (cmd_empty),
        .cmd_pop       (cmd_pop),
        .cmd           (cmd_out),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .res_full      (res_full),
        .res_push      (res_push),
        .new_x         (new_x),
        .new_y         (new_y),
        .buttons       (new_buttons),
        .wheel         (new_wheel),
        .sync_count    (new_sync)
    );

    // Result queue
    pmpd_queue #(
        .WIDTH (RES_W)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata ({new_x, new_y, new_buttons, new_wheel, new_sync}),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    // Result fields
    assign pos_x            = res_rdata[RES_W-1 -: COORD_BITS];
    assign pos_y            = res_rdata[RES_W-COORD_BITS-1 -: COORD_BITS];
    assign button_bits      = res_rdata[22:20];
    assign wheel_step       = $signed(res_rdata[19:16]);
    assign sync_error_count = res_rdata[15:0];

endmodule

@@ sv/pmpd_queue.sv @@
// pmpd_queue: two-entry item queue with registered storage.
// Used between the assembler and cursor stage, and on the result side.
// No package dependencies.
module pmpd_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    logic [WIDTH-1:0] mem [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    // Status
    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ sv/pmpd_front.sv @@
// pmpd_front: byte filter, sync check and packet assembler.
// Emits one cmd_t per completed packet. Depends on pmpd_pkg.
module pmpd_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     ctrl_status,
    input  logic [7:0]                     rx_byte,
    input  logic [pmpd_pkg::LEN_W-1:0]     packet_length,
    input  logic                           cmd_full,
    output logic                           cmd_push,
    output pmpd_pkg::cmd_t                 cmd
);
    import pmpd_pkg::*;

    logic [1:0]  slot_reg, slot_next;
    logic [15:0] sync_reg, sync_next;
    logic [7:0]  pkt_reg [3];

    logic        take;
    logic        len4;
    logic        bad_first;
    logic        store;
    logic [1:0]  last_slot;
    logic [7:0]  b0, b1, b2, b3;

    // Accept and classify
    assign full      = cmd_full;
    assign take      = push && !cmd_full && ((ctrl_status & STATUS_OBF) != 8'h00)
                       && ((ctrl_status & STATUS_AUX) != 8'h00);
    assign len4      = (packet_length == LEN_WHEEL);
    assign last_slot = len4 ? 2'd3 : 2'd2;
    assign bad_first = (slot_reg == 2'd0) && ((rx_byte & FLAG_SYNC) == 8'h00);
    assign store     = (slot_reg < last_slot);
    assign cmd_push  = take && !bad_first && !store;

    // Slot and sync counter
    always_comb
    begin
        slot_next = slot_reg;
        sync_next = sync_reg;
        if (take)
        begin
            if (bad_first)
            begin
                sync_next = sync_reg + 16'd1;
            end
            else if (store)
            begin
                slot_next = slot_reg + 2'd1;
            end
            else
            begin
                slot_next = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= 2'd0;
            sync_reg <= 16'd0;
        end
        else
        begin
            slot_reg <= slot_next;
            sync_reg <= sync_next;
        end
    end

    // Byte storage
    always_ff @(posedge clk)
    begin
        if (take && !bad_first && store)
        begin
            pkt_reg[slot_reg] <= rx_byte;
        end
    end

    // Packet gather: completion happens at slot 2 or slot 3
    assign b0 = pkt_reg[0];
    assign b1 = pkt_reg[1];
    assign b2 = (slot_reg == 2'd2) ? rx_byte : pkt_reg[2];
    assign b3 = (slot_reg == 2'd3) ? rx_byte : 8'h00;

    // Command build
    always_comb
    begin
        cmd.dx = ((b0 & FLAG_XOVF) != 8'h00) ? 9'sd0
                 : $signed({((b0 & FLAG_XSIGN) != 8'h00), b1});
        cmd.dy = ((b0 & FLAG_YOVF) != 8'h00) ? 9'sd0
                 : $signed({((b0 & FLAG_YSIGN) != 8'h00), b2});
        if (len4)
        begin
            cmd.buttons = {((b3 & B3_MIDDLE) != 8'h00), b0[1:0]};
            cmd.wheel   = 4'(b3 & WHEEL_MASK);
        end
        else
        begin
            cmd.buttons = 3'(b0 & BTN_MASK);
            cmd.wheel   = 4'd0;
        end
        cmd.sync_count = sync_reg;
    end

endmodule

@@ sv/pmpd_back.sv @@
// pmpd_back: cursor stage; applies packet deltas and clamps to the screen.
// Consumes cmd_t from the command queue. Depends on pmpd_pkg.
module pmpd_back #(
    parameter int COORD_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_empty,
    output logic                          cmd_pop,
    input  pmpd_pkg::cmd_t                cmd,
    input  logic [pmpd_pkg::SIZE_W-1:0]   screen_width,
    input  logic [pmpd_pkg::SIZE_W-1:0]   screen_height,
    input  logic                          res_full,
    output logic                          res_push,
    output logic [COORD_BITS-1:0]         new_x,
    output logic [COORD_BITS-1:0]         new_y,
    output logic [2:0]                    buttons,
    output logic [3:0]                    wheel,
    output logic [15:0]                   sync_count
);
    import pmpd_pkg::*;

    localparam int SUM_W       = COORD_BITS + 3;
    localparam int LIM_W       = (COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W;
    localparam int COORD_MAX_I = (1 << COORD_BITS) - 1;
    localparam logic [LIM_W-1:0] COORD_MAX_L = LIM_W'({COORD_BITS{1'b1}});
    localparam logic [COORD_BITS-1:0] X_RST =
        COORD_BITS'((CUR_X_RST < COORD_MAX_I) ? CUR_X_RST : COORD_MAX_I);
    localparam logic [COORD_BITS-1:0] Y_RST =
        COORD_BITS'((CUR_Y_RST < COORD_MAX_I) ? CUR_Y_RST : COORD_MAX_I);

    logic [COORD_BITS-1:0]   cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0]   cur_y_reg, cur_y_next;
    logic signed [SUM_W-1:0] sum_x, sum_y;

    // Largest coordinate for a screen size; zero size acts as one
    function automatic logic [COORD_BITS-1:0] axis_limit(input logic [SIZE_W-1:0] size);
        logic [LIM_W-1:0] lim;
        lim = LIM_W'(size);
        if (lim == '0)
        begin
            lim = LIM_W'(1);
        end
        lim = lim - LIM_W'(1);
        if (lim > COORD_MAX_L)
        begin
            lim = COORD_MAX_L;
        end
        return COORD_BITS'(lim);
    endfunction

    // Clamp a signed sum into [0, lim]
    function automatic logic [COORD_BITS-1:0] clamp_axis(input logic signed [SUM_W-1:0] v,
                                                        input logic [COORD_BITS-1:0] lim);
        logic signed [SUM_W-1:0] lim_s;
        lim_s = $signed({{(SUM_W-COORD_BITS){1'b0}}, lim});
        if (v < 0)
        begin
            return '0;
        end
        if (v > lim_s)
        begin
            return lim;
        end
        return COORD_BITS'(v);
    endfunction

    // Handshake: one packet per cycle while results can be stored
    assign cmd_pop  = !cmd_empty && !res_full;
    assign res_push = cmd_pop;

    // Delta application
    assign sum_x = $signed({{(SUM_W-COORD_BITS){1'b0}}, cur_x_reg}) + SUM_W'(cmd.dx);
    assign sum_y = $signed({{(SUM_W-COORD_BITS){1'b0}}, cur_y_reg}) - SUM_W'(cmd.dy);

    assign cur_x_next = clamp_axis(sum_x, axis_limit(screen_width));
    assign cur_y_next = clamp_axis(sum_y, axis_limit(screen_height));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg <= X_RST;
            cur_y_reg <= Y_RST;
        end
        else if (cmd_pop)
        begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
        end
    end

    // Result item
    assign new_x      = cur_x_next;
    assign new_y      = cur_y_next;
    assign buttons    = cmd.buttons;
    assign wheel      = cmd.wheel;
    assign sync_count = cmd.sync_count;

endmodule

@@ dv/ps2_mouse_packet_decoder_core_tb.sv @@
// Self-checking testbench for ps2_mouse_packet_decoder_core: directed bytes, then
// random packets under several screen/length settings and flow-control patterns.
// Depends on pmpd_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module ps2_mouse_packet_decoder_core_tb;
    import pmpd_pkg::*;

    localparam int COORD_BITS  = 12;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
    localparam int LAT_PAD     = 8;       // settle cycles once results are drained
    localparam int HOLD_CYCLES = 300;     // long receiver hold-off
    localparam int CYCLE_LIMIT = 200000;
    localparam int FINAL_WAIT  = 20000;
    localparam int NUM_PHASES  = 8;
    localparam int PRESSURE_PHASE = 4;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

    // One decoded cursor report
    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [2:0]            btn;
        logic signed [3:0]     wheel;
        logic [15:0]           sync;
    } mouse_report_t;

    typedef struct {
        logic [7:0]    st;
        logic [7:0]    db;
        bit            typed;
        mouse_report_t want;
    } stim_row_t;

    typedef struct {
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
        logic [LEN_W-1:0]  len;
        idle_mode_e        mode;
        int                n;
    } phase_t;

    // DUT ports
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [PDATA_W-1:0]     pwdata = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;
    logic                   push = 1'b0;
    logic                   full;
    logic [7:0]             ctrl_status = '0;
    logic [7:0]             rx_byte = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [COORD_BITS-1:0]  pos_x;
    logic [COORD_BITS-1:0]  pos_y;
    logic [2:0]             button_bits;
    logic signed [3:0]      wheel_step;
    logic [15:0]            sync_error_count;

    // Decoder shadow state and register copies
    logic [SIZE_W-1:0]      cfg_width  = SCREEN_WIDTH_RST;
    logic [SIZE_W-1:0]      cfg_height = SCREEN_HEIGHT_RST;
    logic [LEN_W-1:0]       cfg_len    = PACKET_LENGTH_RST;
    logic [1:0]             mdl_slot   = 2'd0;
    logic [7:0]             mdl_bytes [3];
    int                     mdl_x      = CUR_X_RST;
    int                     mdl_y      = CUR_Y_RST;
    logic [15:0]            mdl_sync   = 16'd0;

    mouse_report_t          pending_reports [$];
    stim_row_t              directed [$];
    phase_t                 plan [NUM_PHASES];

    idle_mode_e             idle_mode = IDLE_NONE;
    int                     burst_left [2] = '{0, 0};
    int                     hold_req = 0;
    int                     hold_ack = 0;
    int                     hold_left = 0;
    int                     err_cnt = 0;
    int                     cycle_cnt = 0;

    ps2_mouse_packet_decoder_core #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .push             (push),
        .full             (full),
        .ctrl_status      (ctrl_status),
        .rx_byte          (rx_byte),
        .empty            (empty),
        .pop              (pop),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .button_bits      (button_bits),
        .wheel_step       (wheel_step),
        .sync_error_count (sync_error_count)
    );

    always #5 clk = ~clk;

    // Run-length guard
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("ps2_mouse_packet_decoder_core regression: fail");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        err_cnt++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Clamp a coordinate into [0, size-1]; size 0 acts as 1, top capped by coord range
    function automatic int clamp_coord(input int v, input logic [SIZE_W-1:0] size);
        int lim;
        lim = (size == '0) ? 0 : int'(size) - 1;
        if (lim > COORD_MAX)
            lim = COORD_MAX;
        if (v < 0)
            return 0;
        if (v > lim)
            return lim;
        return v;
    endfunction

    // 9-bit signed movement; overflow drops it
    function automatic int axis_delta(input logic [7:0] raw, input bit neg, input bit ovf);
        int d;
        d = int'(raw);
        if (neg)
            d -= 256;
        if (ovf)
            d = 0;
        return d;
    endfunction

    // Advance the shadow decoder by one accepted byte
    task automatic decode_byte(input logic [7:0] st, input logic [7:0] db,
                               output bit got, output mouse_report_t rep);
        logic [7:0] pkt [4];
        logic [7:0] flags;
        logic [2:0] btn;
        logic [3:0] whl;
        int         len;
        int         s;
        int         i;
        got = 1'b0;
        rep = '0;
        len = (cfg_len == LEN_WHEEL) ? 4 : 3;
        s   = int'(mdl_slot);
        if ((st & STATUS_OBF) == 8'h00 || (st & STATUS_AUX) == 8'h00)
            return;
        // first byte must carry the sync bit
        if (s == 0 && (db & FLAG_SYNC) == 8'h00)
        begin
            mdl_sync = mdl_sync + 16'd1;
            return;
        end
        if (s + 1 < len)
        begin
            mdl_bytes[s] = db;
            mdl_slot = 2'(s + 1);
            return;
        end
        // packet done; current byte lands at slot s (unused if length was lowered)
        for (i = 0; i < 3; i++)
            pkt[i] = mdl_bytes[i];
        pkt[3] = 8'h00;
        pkt[s] = db;
        mdl_slot = 2'd0;
        flags = pkt[0];
        mdl_x = clamp_coord(mdl_x + axis_delta(pkt[1], (flags & FLAG_XSIGN) != 0,
                                               (flags & FLAG_XOVF) != 0), cfg_width);
        mdl_y = clamp_coord(mdl_y - axis_delta(pkt[2], (flags & FLAG_YSIGN) != 0,
                                               (flags & FLAG_YOVF) != 0), cfg_height);
        btn = 3'(flags & BTN_MASK);
        whl = 4'd0;
        if (len == 4)
        begin
            whl = 4'(pkt[3] & WHEEL_MASK);
            btn[2] = (pkt[3] & B3_MIDDLE) != 0;
        end
        rep.x     = COORD_BITS'(mdl_x);
        rep.y     = COORD_BITS'(mdl_y);
        rep.btn   = btn;
        rep.wheel = whl;
        rep.sync  = mdl_sync;
        got = 1'b1;
    endtask

    // Random idle decision per side (0 sender, 1 receiver), with idle-free bursts
    function automatic bit side_idle(input bit rx);
        int pct;
        if (idle_mode == IDLE_BOTH)
            pct = 6;
        else if ((rx && idle_mode == IDLE_RECV) || (!rx && idle_mode == IDLE_SEND))
            pct = 74;
        else
            pct = 0;
        if (pct == 0)
            return 1'b0;
        if (burst_left[rx] != 0)
        begin
            burst_left[rx]--;
            return 1'b0;
        end
        if ($urandom_range(99) < 3)
        begin
            burst_left[rx] = $urandom_range(10, 30);
            return 1'b0;
        end
        return $urandom_range(99) < pct;
    endfunction

    // Offer one item, wait for acceptance, then predict
    task automatic send_item(input logic [7:0] st, input logic [7:0] db,
                             input bit typed, input mouse_report_t want);
        bit            got;
        mouse_report_t rep;
        if (side_idle(1'b0))
        begin
            push <= 1'b0;
            do
                @(posedge clk);
            while (side_idle(1'b0));
        end
        push        <= 1'b1;
        ctrl_status <= st;
        rx_byte     <= db;
        do
            @(posedge clk);
        while (full);
        decode_byte(st, db, got, rep);
        if (got)
            pending_reports.push_back(typed ? want : rep);
    endtask

    // Stop sending and let all expected reports drain
    task automatic wait_idle();
        push <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (LAT_PAD) @(posedge clk);
    endtask

    // Close out a partial packet with random data bytes
    task automatic finish_packet();
        while (mdl_slot != 2'd0)
            send_item(8'($urandom) | STATUS_OBF | STATUS_AUX, 8'($urandom), 1'b0, '0);
    endtask

    // One APB transfer: setup, access, then return to idle
    task automatic apb_xfer(input bit wr, input logic [1:0] idx, input logic [31:0] wd,
                            output logic [31:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wd;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic cfg_expect(input logic [1:0] idx, input logic [31:0] want);
        logic [31:0] rd;
        apb_xfer(1'b0, idx, 32'd0, rd);
        if (rd !== want)
            flag_mismatch($sformatf("reg %0d read 0x%0h want 0x%0h", idx, rd, want));
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] rd;
        logic [31:0] want;
        apb_xfer(1'b1, idx, value, rd);
        case (idx)
            REG_SCREEN_WIDTH:  cfg_width  = value[SIZE_W-1:0];
            REG_SCREEN_HEIGHT: cfg_height = value[SIZE_W-1:0];
            REG_PACKET_LENGTH: cfg_len    = value[LEN_W-1:0];
            default: ;
        endcase
        case (idx)
            REG_SCREEN_WIDTH:  want = 32'(cfg_width);
            REG_SCREEN_HEIGHT: want = 32'(cfg_height);
            default:           want = 32'(cfg_len);
        endcase
        cfg_expect(idx, want);
    endtask

    task automatic add_step(input logic [7:0] st, input logic [7:0] db, input bit typed,
                            input int x, input int y, input int btn, input int sync);
        stim_row_t row;
        row.st = st;
        row.db = db;
        row.typed = typed;
        row.want = '0;
        row.want.x = COORD_BITS'(x);
        row.want.y = COORD_BITS'(y);
        row.want.btn = 3'(btn);
        row.want.sync = 16'(sync);
        directed.push_back(row);
    endtask

    // Random traffic: mostly whole packets, some partial ones, stray and unsynced bytes
    task automatic run_random(input int n, input bit pressure);
        int         sent;
        int         r;
        int         k;
        int         j;
        int         plen;
        bit         held;
        bit         paused;
        logic [7:0] st;
        logic [7:0] db;
        sent = 0;
        held = 1'b0;
        paused = 1'b0;
        while (sent < n)
        begin
            if (pressure && !held && sent >= n / 2)
            begin
                hold_req++;
                held = 1'b1;
            end
            if (pressure && held && !paused && sent >= (3 * n) / 4)
            begin
                wait_idle();
                paused = 1'b1;
            end
            r = $urandom_range(99);
            plen = (cfg_len == LEN_WHEEL) ? 4 : 3;
            if (r < 8)
            begin
                st = 8'($urandom);
                send_item(st, 8'($urandom), 1'b0, '0);
                if ((st & STATUS_OBF) != 0 && (st & STATUS_AUX) != 0)
                    sent++;
            end
            else if (r < 14)
            begin
                db = 8'($urandom) & ~FLAG_SYNC;
                send_item(8'($urandom) | STATUS_OBF | STATUS_AUX, db, 1'b0, '0);
                sent++;
            end
            else
            begin
                finish_packet();
                k = (r < 18) ? $urandom_range(1, plen - 1) : plen;
                for (j = 0; j < k; j++)
                begin
                    db = 8'($urandom);
                    if (j == 0)
                    begin
                        db = db | FLAG_SYNC;
                        // keep most packets free of overflow so the cursor moves
                        if ($urandom_range(3) != 0)
                            db = db & ~(FLAG_XOVF | FLAG_YOVF);
                    end
                    send_item(8'($urandom) | STATUS_OBF | STATUS_AUX, db, 1'b0, '0);
                end
                sent += k;
            end
        end
    endtask

    // Result check against the oldest expectation
    task automatic check_report();
        mouse_report_t want;
        if (pending_reports.size() == 0)
        begin
            flag_mismatch("result with nothing expected");
            return;
        end
        want = pending_reports.pop_front();
        if (pos_x !== want.x)
            flag_mismatch($sformatf("pos_x %0d want %0d", pos_x, want.x));
        if (pos_y !== want.y)
            flag_mismatch($sformatf("pos_y %0d want %0d", pos_y, want.y));
        if (button_bits !== want.btn)
            flag_mismatch($sformatf("button_bits %0d want %0d", button_bits, want.btn));
        if (wheel_step !== want.wheel)
            flag_mismatch($sformatf("wheel_step %0d want %0d", wheel_step, want.wheel));
        if (sync_error_count !== want.sync)
            flag_mismatch($sformatf("sync_error_count %0d want %0d",
                                    sync_error_count, want.sync));
    endtask

    // Receiver hold-off timer
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_ack != hold_req)
        begin
            hold_left <= HOLD_CYCLES;
            hold_ack  <= hold_req;
        end
    end

    // Result side: pop and check
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
                check_report();
            pop <= (hold_left == 0) && !side_idle(1'b1);
        end
    end

    // Main sequence
    initial
    begin
        int          pi;
        int          j;
        int          waited;
        logic [7:0]  db;

        // Directed bytes: status gating, sync errors, sign/overflow extremes
        add_step(8'h00, 8'h08, 1'b0, 0, 0, 0, 0);
        add_step(8'h01, 8'h08, 1'b0, 0, 0, 0, 0);
        add_step(8'h20, 8'h08, 1'b0, 0, 0, 0, 0);
        add_step(8'h21, 8'h00, 1'b0, 0, 0, 0, 0);
        add_step(8'h21, 8'hF7, 1'b0, 0, 0, 0, 0);
        add_step(8'h21, 8'h08, 1'b0, 0, 0, 0, 0);
        add_step(8'h21, 8'h00, 1'b0, 0, 0, 0, 0);
        add_step(8'h21, 8'h00, 1'b1, 640, 360, 0, 2);
        add_step(8'h21, 8'h0F, 1'b0, 0, 0, 0, 0);
        add_step(8'h21, 8'h7F, 1'b0, 0, 0, 0, 0);
        add_step(8'h21, 8'h7F, 1'b1, 767, 233, 7, 2);
        add_step(8'h21, 8'h38, 1'b0, 0, 0, 0, 0);
        add_step(8'h21, 8'h00, 1'b0, 0, 0, 0, 0);
        add_step(8'h21, 8'h00, 1'b1, 511, 489, 0, 2);
        add_step(8'h21, 8'hC8, 1'b0, 0, 0, 0, 0);
        add_step(8'h21, 8'hFF, 1'b0, 0, 0, 0, 0);
        add_step(8'h21, 8'hFF, 1'b1, 511, 489, 0, 2);
        add_step(8'hFF, 8'hFF, 1'b0, 0, 0, 0, 0);
        add_step(8'hFF, 8'hFF, 1'b0, 0, 0, 0, 0);
        add_step(8'hFF, 8'hFF, 1'b1, 511, 489, 7, 2);
        add_step(8'h21, 8'h18, 1'b0, 0, 0, 0, 0);
        add_step(8'h21, 8'hFF, 1'b0, 0, 0, 0, 0);
        add_step(8'h21, 8'h01, 1'b0, 0, 0, 0, 0);
        add_step(8'h3D, 8'h0A, 1'b0, 0, 0, 0, 0);
        add_step(8'hE1, 8'h80, 1'b0, 0, 0, 0, 0);
        add_step(8'h21, 8'h7F, 1'b0, 0, 0, 0, 0);

        // Settings per phase: extremes of size and length, each idling pattern
        plan[0] = '{13'd1280, 13'd720,  3'd3, IDLE_NONE, 90};
        plan[1] = '{13'd4096, 13'd4096, 3'd4, IDLE_SEND, 90};
        plan[2] = '{13'd1,    13'd1,    3'd4, IDLE_RECV, 80};
        plan[3] = '{13'd0,    13'd0,    3'd7, IDLE_BOTH, 80};
        plan[4] = '{13'd8191, 13'd8191, 3'd4, IDLE_NONE, 90};
        plan[5] = '{13'd100,  13'd50,   3'd0, IDLE_SEND, 80};
        plan[6] = '{13'd300,  13'd300,  3'd3, IDLE_RECV, 90};
        plan[7] = '{13'd640,  13'd480,  3'd4, IDLE_BOTH, 90};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers come up at their reset values
        cfg_expect(REG_SCREEN_WIDTH,  32'(SCREEN_WIDTH_RST));
        cfg_expect(REG_SCREEN_HEIGHT, 32'(SCREEN_HEIGHT_RST));
        cfg_expect(REG_PACKET_LENGTH, 32'(PACKET_LENGTH_RST));

        foreach (directed[i])
            send_item(directed[i].st, directed[i].db, directed[i].typed, directed[i].want);

        for (pi = 0; pi < NUM_PHASES; pi++)
        begin
            wait_idle();
            if (pi == 6)
            begin
                plan[pi].w   = SIZE_W'($urandom_range(1, 300));
                plan[pi].h   = SIZE_W'($urandom_range(1, 300));
                plan[pi].len = LEN_W'($urandom_range(0, 7));
            end
            idle_mode = plan[pi].mode;
            cfg_write(REG_SCREEN_WIDTH,  32'(plan[pi].w));
            cfg_write(REG_SCREEN_HEIGHT, 32'(plan[pi].h));
            cfg_write(REG_PACKET_LENGTH, 32'(plan[pi].len));
            run_random(plan[pi].n, pi == PRESSURE_PHASE);

            // Length lowered with three bytes pending: next byte completes a 3-byte packet
            if (pi == 1)
            begin
                finish_packet();
                for (j = 0; j < 3; j++)
                begin
                    db = 8'($urandom);
                    if (j == 0)
                        db = db | FLAG_SYNC;
                    send_item(8'($urandom) | STATUS_OBF | STATUS_AUX, db, 1'b0, '0);
                end
                wait_idle();
                cfg_write(REG_PACKET_LENGTH, 32'(PACKET_LENGTH_RST));
                send_item(8'($urandom) | STATUS_OBF | STATUS_AUX, 8'($urandom), 1'b0, '0);
            end
        end

        // Drain and finish
        idle_mode = IDLE_NONE;
        push <= 1'b0;
        waited = 0;
        while (pending_reports.size() != 0 && waited < FINAL_WAIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LAT_PAD) @(posedge clk);
        if (pending_reports.size() != 0)
            flag_mismatch($sformatf("%0d expected results never arrived",
                                    pending_reports.size()));

        if (err_cnt == 0)
            $display("ps2_mouse_packet_decoder_core regression: pass");
        else
            $display("ps2_mouse_packet_decoder_core regression: fail");
        $finish;
    end

endmodule
